[src/bdd_pkg.sv]
// Shared constants, register codes and beat types of the balanced digit decomposer.
`default_nettype none

package bdd_pkg;

  // Width of the signed working values and of the shared divider.
  localparam int COEFF_WIDTH    = 64;
  localparam int DEF_MAX_DIGITS = 64;

  localparam int VALUE_W   = 63;
  localparam int BASE_W    = 32;
  localparam int COUNT_W   = 7;
  localparam int INDEX_W   = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd2;

  localparam logic [VALUE_W-1:0] MODULUS_RST = 63'd2147483647;
  localparam logic [BASE_W-1:0]  BASE_RST    = 32'd2;
  localparam logic [COUNT_W-1:0] COUNT_RST   = 7'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] coefficient;
  } coeff_beat_t;

  typedef struct packed {
    logic [VALUE_W-1:0] digit_value;
    logic [INDEX_W-1:0] digit_index;
    logic               last_digit;
    logic               high_overflow;
  } digit_beat_t;

endpackage

`default_nettype wire

[src/bdd_chan_if.sv]
// Valid/ready stream channel carrying one beat of a packed payload type.
`default_nettype none

interface bdd_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/bdd_div.sv]
// Restoring unsigned divider that resolves one quotient bit per cycle.
`default_nettype none

module bdd_div #(
  parameter int W = bdd_pkg::COEFF_WIDTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  part;
  logic [W-1:0]  quo;
  logic [W-1:0]  dsr;
  logic [W:0]    trial;
  logic          borrow;

  // Shift the next dividend bit into the partial remainder and try the subtraction.
  assign trial  = {part, quo[W-1]} - {1'b0, dsr};
  assign borrow = trial[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part <= '0;
      quo  <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      part <= borrow ? {part[W-2:0], quo[W-1]} : trial[W-1:0];
      quo  <= {quo[W-2:0], ~borrow};
    end
  end

  assign quotient  = quo;
  assign remainder = part;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

`default_nettype wire

[src/balanced_digit_decomposer_top.sv]
// Top level of the balanced digit decomposer: config registers, sequencer and output register.
// Each digit below the top waits on the shared divider for the divide by the base, and again
// when it must be reduced modulo q; the high part skips the divide by the base.
// A new coefficient is accepted only in the idle state, after the previous one's last digit is
// handed over; the pace is set by the single shared restoring divider, one quotient bit per cycle.
// Reset: synchronous active-high rst loads the register defaults and empties the block.
`default_nettype none

module balanced_digit_decomposer_top #(
  parameter int MAX_DIGITS = bdd_pkg::DEF_MAX_DIGITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic [bdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bdd_pkg::VALUE_W-1:0]    cfg_data,
  bdd_chan_if.sink                            coeff,
  bdd_chan_if.source                          digit
);
  import bdd_pkg::*;

  localparam int W  = COEFF_WIDTH;
  localparam int KW = $clog2(MAX_DIGITS);

  // One-hot sequencer states. Each digit walks NEXT, DIV, FLOOR, BAL, ENC, (MOD), FIX, EMIT;
  // the final digit skips the divide by the base, and a zero modulus goes from ENC to EMIT.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_NEXT  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_FLOOR = 9'b000001000,
    S_BAL   = 9'b000010000,
    S_ENC   = 9'b000100000,
    S_MOD   = 9'b001000000,
    S_FIX   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [VALUE_W-1:0] modulus;
  logic [BASE_W-1:0]  digit_base;
  logic [COUNT_W-1:0] digit_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= MODULUS_RST;
      digit_base  <= BASE_RST;
      digit_count <= COUNT_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_MODULUS: modulus     <= cfg_data;
        REG_BASE:    digit_base  <= cfg_data[BASE_W-1:0];
        REG_COUNT:   digit_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived settings. A base below two acts as two, and the digit count is clamped into
  // the range from two to MAX_DIGITS.
  logic [W-1:0]       q_ext;
  logic [W-1:0]       q_half;
  logic [BASE_W-1:0]  b_eff;
  logic [BASE_W-1:0]  b_half;
  logic [COUNT_W-1:0] count_c;
  logic [KW-1:0]      n_last;

  assign q_ext  = {1'b0, modulus};
  assign q_half = q_ext >> 1;
  assign b_eff  = (digit_base < BASE_W'(2)) ? BASE_W'(2) : digit_base;
  assign b_half = b_eff >> 1;

  always_comb begin
    if (digit_count < COUNT_W'(2)) begin
      count_c = COUNT_W'(2);
    end else if (digit_count > COUNT_W'(MAX_DIGITS)) begin
      count_c = COUNT_W'(MAX_DIGITS);
    end else begin
      count_c = digit_count;
    end
  end

  assign n_last = KW'(count_c - COUNT_W'(1));

  // Working registers: the running quotient, the digit being formed and its residue.
  logic signed [W-1:0] val;
  logic signed [W-1:0] dig;
  logic [BASE_W-1:0]   rem_u;
  logic [VALUE_W-1:0]  rmod;
  logic [VALUE_W-1:0]  enc;
  logic                ovf;
  logic [KW-1:0]       kcnt;
  logic                is_last;

  logic [W-1:0] mag_val;
  logic [W-1:0] mag_dig;
  logic [W-1:0] recentered;
  logic [W-1:0] in_ext;

  assign is_last    = (kcnt == n_last);
  assign mag_val    = val[W-1] ? (W'(0) - val) : val;
  assign mag_dig    = dig[W-1] ? (W'(0) - dig) : dig;
  assign in_ext     = {1'b0, coeff.data.coefficient};
  assign recentered = (in_ext > q_half) ? (in_ext - q_ext) : in_ext;

  // Shared divider: divides the running value by the base, and reduces a digit modulo q.
  logic         div_start;
  logic [W-1:0] div_dividend;
  logic [W-1:0] div_divisor;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;
  logic         need_mod;

  assign need_mod = (modulus != '0) && !(mag_dig < q_ext);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = mag_val;
    div_divisor  = {{(W - BASE_W){1'b0}}, b_eff};
    case (state)
      S_NEXT: begin
        div_start = !is_last;
      end
      S_ENC: begin
        div_start    = need_mod;
        div_dividend = mag_dig;
        div_divisor  = q_ext;
      end
      default: ;
    endcase
  end

  bdd_div #(
    .W (W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Output register: the sequencer may hand over a new beat while the old one leaves.
  logic        out_valid;
  digit_beat_t out_beat;
  logic        out_free;

  assign out_free    = !out_valid || digit.ready;
  assign digit.valid = out_valid;
  assign digit.data  = out_beat;
  assign coeff.ready = (state == S_IDLE);

  // The output beat is valid from the hand-over until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (digit.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kcnt      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (coeff.valid) begin
            kcnt  <= '0;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          state <= is_last ? S_ENC : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FLOOR;
          end
        end
        S_FLOOR: begin
          state <= S_BAL;
        end
        S_BAL: begin
          state <= S_ENC;
        end
        S_ENC: begin
          if (modulus == '0) begin
            state <= S_EMIT;
          end else if (need_mod) begin
            state <= S_MOD;
          end else begin
            state <= S_FIX;
          end
        end
        S_MOD: begin
          if (div_done) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              kcnt  <= kcnt + KW'(1);
              state <= S_NEXT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        val <= recentered;
      end
      S_NEXT: begin
        // The last digit is whatever remains of the value; flag it when it lies outside
        // plus or minus q/2.
        if (is_last) begin
          dig <= val;
          ovf <= (val < -$signed(q_half)) || (val > $signed(q_half));
        end else begin
          ovf <= 1'b0;
        end
      end
      S_FLOOR: begin
        // Turn the truncated divide of the magnitude into a floor division.
        if (!val[W-1]) begin
          val   <= div_quo;
          rem_u <= div_rem[BASE_W-1:0];
        end else if (div_rem == '0) begin
          val   <= W'(0) - div_quo;
          rem_u <= '0;
        end else begin
          val   <= ~div_quo;
          rem_u <= b_eff - div_rem[BASE_W-1:0];
        end
      end
      S_BAL: begin
        // Remainders above half the base become negative with a carry into the quotient.
        if (rem_u > b_half) begin
          dig <= {{(W - BASE_W){1'b0}}, rem_u} - {{(W - BASE_W){1'b0}}, b_eff};
          val <= val + W'(1);
        end else begin
          dig <= {{(W - BASE_W){1'b0}}, rem_u};
        end
      end
      S_ENC: begin
        if (modulus == '0) begin
          enc <= dig[VALUE_W-1:0];
        end else begin
          rmod <= mag_dig[VALUE_W-1:0];
        end
      end
      S_MOD: begin
        if (div_done) begin
          rmod <= div_rem[VALUE_W-1:0];
        end
      end
      S_FIX: begin
        // A negative digit is sent as q minus its residue, and zero stays zero.
        if (dig[W-1] && (rmod != '0)) begin
          enc <= modulus - rmod;
        end else begin
          enc <= rmod;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_beat.digit_value   <= enc;
          out_beat.digit_index   <= INDEX_W'(kcnt);
          out_beat.last_digit    <= is_last;
          out_beat.high_overflow <= is_last && ovf;
        end
      end
      default: ;
    endcase
  end

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV || state == S_MOD))
    else $error("divider finished outside a waiting state");
  a_ovf_last_only: assert property (@(posedge clk) disable iff (rst)
    digit.valid && !digit.data.last_digit |-> !digit.data.high_overflow)
    else $error("overflow flagged on a digit that is not the last");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    coeff.valid && coeff.ready |=> state == S_NEXT)
    else $error("accepted coefficient did not start the sequencer");
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    digit.valid |-> digit.data.digit_index <= INDEX_W'(n_last))
    else $error("digit index beyond the digit count");

endmodule

`default_nettype wire

[verif/bdd_digit_checker.sv]
// Checker that predicts every digit beat of the decomposer and compares it with the output.
`default_nettype none

module bdd_digit_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [bdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdd_pkg::VALUE_W-1:0]   cfg_data,
  input  wire logic                          coeff_valid,
  input  wire logic                          coeff_ready,
  input  wire bdd_pkg::coeff_beat_t          coeff_data,
  input  wire logic                          digit_valid,
  input  wire logic                          digit_ready,
  input  wire bdd_pkg::digit_beat_t          digit_data,
  output int                                 mismatches,
  output int                                 digits_owed
);
  import bdd_pkg::*;

  // Shadow copy of the register file, kept up to date from the write port.
  logic [VALUE_W-1:0] mod_q;
  logic [BASE_W-1:0]  base_reg;
  logic [COUNT_W-1:0] count_reg;

  digit_beat_t pending_digits[$];

  task automatic report_mismatch(input string msg);
    $display("digit check: %s", msg);
    mismatches++;
  endtask

  // Encodes a signed digit as an element of Z_q and packs it into a beat.
  function automatic digit_beat_t make_digit(longint v, int k, logic last, logic ovf);
    digit_beat_t d;
    logic [63:0] q;
    logic [63:0] raw;
    logic [63:0] mag;
    q   = {1'b0, mod_q};
    raw = v;
    if (v >= 0) begin
      mag = raw;
      if (q != 0)
        mag = raw % q;
    end else if (q == 0) begin
      mag = raw;
    end else begin
      mag = (64'd0 - raw) % q;
      if (mag != 0)
        mag = q - mag;
    end
    d.digit_value   = mag[VALUE_W-1:0];
    d.digit_index   = INDEX_W'(k);
    d.last_digit    = last;
    d.high_overflow = ovf;
    return d;
  endfunction

  task automatic predict_digits(input logic [VALUE_W-1:0] coefficient);
    longint q_s;
    longint q_half;
    longint b;
    longint b_half;
    longint val;
    longint quo;
    longint rem;
    int     n;
    int     k;
    q_s    = longint'({1'b0, mod_q});
    q_half = q_s / 2;
    b      = longint'({32'd0, base_reg});
    if (b < 2)
      b = 2;
    b_half = b / 2;
    n = count_reg;
    if (n < 2)
      n = 2;
    if (n > DEF_MAX_DIGITS)
      n = DEF_MAX_DIGITS;
    val = longint'({1'b0, coefficient});
    if (val > q_half)
      val = val - q_s;
    for (k = 0; k < n - 1; k++) begin
      quo = val / b;
      rem = val % b;
      if (rem < 0) begin
        quo = quo - 1;
        rem = rem + b;
      end
      if (rem > b_half) begin
        rem = rem - b;
        quo = quo + 1;
      end
      pending_digits = {pending_digits, make_digit(rem, k, 1'b0, 1'b0)};
      val = quo;
    end
    pending_digits = {pending_digits,
                      make_digit(val, n - 1, 1'b1, (val < -q_half) || (val > q_half))};
  endtask

  always @(posedge clk) begin
    digit_beat_t want;
    if (rst) begin
      mod_q     = MODULUS_RST;
      base_reg  = BASE_RST;
      count_reg = COUNT_RST;
      pending_digits.delete();
      digits_owed <= 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_MODULUS: mod_q = cfg_data;
          REG_BASE:    base_reg = cfg_data[BASE_W-1:0];
          REG_COUNT:   count_reg = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (coeff_valid && coeff_ready)
        predict_digits(coeff_data.coefficient);
      if (digit_valid && digit_ready) begin
        if (pending_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, value %0h index %0d last %0b",
                                    digit_data.digit_value, digit_data.digit_index,
                                    digit_data.last_digit));
        end else begin
          want = pending_digits.pop_front();
          if (digit_data.digit_value !== want.digit_value)
            report_mismatch($sformatf("digit_value got %0h want %0h (index %0d)",
                                      digit_data.digit_value, want.digit_value,
                                      want.digit_index));
          if (digit_data.digit_index !== want.digit_index)
            report_mismatch($sformatf("digit_index got %0d want %0d",
                                      digit_data.digit_index, want.digit_index));
          if (digit_data.last_digit !== want.last_digit)
            report_mismatch($sformatf("last_digit got %0b want %0b (index %0d)",
                                      digit_data.last_digit, want.last_digit,
                                      want.digit_index));
          if (digit_data.high_overflow !== want.high_overflow)
            report_mismatch($sformatf("high_overflow got %0b want %0b (index %0d)",
                                      digit_data.high_overflow, want.high_overflow,
                                      want.digit_index));
        end
      end
      digits_owed <= pending_digits.size();
    end
  end

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Testbench top: clock, reset, coefficient and register stimulus, digit sink and verdict.
`default_nettype none

module tb_top;
  import bdd_pkg::*;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
  localparam logic [BASE_W-1:0]  BASE_MAX  = '1;

  // A single digit takes longest when it needs a reduction modulo q, and the digit sink may
  // stall on top of that. A silence far longer than one such beat means the block is stuck.
  localparam int STALL_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VALUE_W-1:0] cfg_data;

  // When set, neither side inserts idle cycles, so the block runs back to back.
  bit                 calm;
  int                 quiet_cycles;
  int                 mismatches;
  int                 digits_owed;

  bdd_chan_if #(.T(coeff_beat_t)) coeff_ch ();
  bdd_chan_if #(.T(digit_beat_t)) digit_ch ();

  balanced_digit_decomposer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeff     (coeff_ch),
    .digit     (digit_ch)
  );

  bdd_digit_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .coeff_valid (coeff_ch.valid),
    .coeff_ready (coeff_ch.ready),
    .coeff_data  (coeff_ch.data),
    .digit_valid (digit_ch.valid),
    .digit_ready (digit_ch.ready),
    .digit_data  (digit_ch.data),
    .mismatches  (mismatches),
    .digits_owed (digits_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Draws how many cycles a side waits before its next beat. About a quarter of the draws
  // are zero even outside calm phases, so short bursts also show up in the busy phases.
  function automatic int idle_cycles();
    if (calm || $urandom_range(0, 3) == 0)
      return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [VALUE_W-1:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[VALUE_W-1:0];
  endfunction

  // Offers one coefficient beat and returns in the time step of the edge that accepts it.
  // With a zero gap, valid simply stays high and only the payload changes.
  task automatic send_coeff(input logic [VALUE_W-1:0] value);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      coeff_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coeff_ch.valid <= 1'b1;
    coeff_ch.data  <= coeff_beat_t'(value);
    @(posedge clk);
    while (!coeff_ch.ready) @(posedge clk);
  endtask

  // Stops offering coefficients and waits until every predicted digit has come out.
  // The first edge lets the checker's count take in a beat accepted at the calling edge.
  task automatic drain();
    coeff_ch.valid <= 1'b0;
    @(posedge clk);
    while (digits_owed != 0) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges. Base and count writes sometimes carry
  // junk above the register width, which the block must drop.
  task automatic program_regs(input logic [VALUE_W-1:0] modv, input logic [BASE_W-1:0] basev,
                              input logic [COUNT_W-1:0] countv);
    logic [VALUE_W-1:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? rand63() : '0;
    cfg_wen   <= 1'b1;
    cfg_index <= REG_MODULUS;
    cfg_data  <= modv;
    @(posedge clk);
    cfg_index <= REG_BASE;
    cfg_data  <= {junk[VALUE_W-1:BASE_W], basev};
    @(posedge clk);
    cfg_index <= REG_COUNT;
    cfg_data  <= {junk[VALUE_W-1:COUNT_W], countv};
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Digit sink: before each beat it may hold ready low for a random number of cycles,
  // then keeps ready high until a beat is taken.
  initial begin
    int stall;
    digit_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        digit_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      digit_ch.ready <= 1'b1;
      @(posedge clk);
      while (!digit_ch.valid) @(posedge clk);
    end
  end

  // The watchdog ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (coeff_ch.valid && coeff_ch.ready) || (digit_ch.valid && digit_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[balanced_digit_decomposer_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] c;
    logic [BASE_W-1:0]  b;
    logic [COUNT_W-1:0] n;
    int                 ph;
    int                 i;
    int                 items;
    int                 w;

    calm           = 1'b0;
    rst           <= 1'b1;
    cfg_wen       <= 1'b0;
    cfg_index     <= REG_MODULUS;
    cfg_data      <= '0;
    coeff_ch.valid <= 1'b0;
    coeff_ch.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Register defaults straight out of reset (q = 2^31-1, base 2, two digits): zero, one,
    // both sides of the recentering point, the top of the range, and a coefficient far
    // above the modulus that is only recentered once and overflows the high part.
    send_coeff(63'd0);
    send_coeff(63'd1);
    send_coeff(63'd1073741823);
    send_coeff(63'd1073741824);
    send_coeff(63'd2147483646);
    send_coeff(VALUE_MAX);
    drain();

    // Widest modulus and widest base.
    program_regs(VALUE_MAX, BASE_MAX, 7'd3);
    send_coeff(63'd0);
    send_coeff(VALUE_MAX >> 1);
    send_coeff((VALUE_MAX >> 1) + 63'd1);
    send_coeff(VALUE_MAX - 63'd1);
    drain();

    // The full digit count with the smallest base.
    program_regs(VALUE_MAX, 32'd2, 7'd64);
    send_coeff(VALUE_MAX - 63'd1);
    send_coeff(VALUE_MAX >> 1);
    drain();

    // Base zero and one behave as base two; counts zero and one are raised to two.
    program_regs(63'd3, 32'd0, 7'd0);
    send_coeff(63'd2);
    send_coeff(63'd1);
    drain();
    program_regs(63'd3, 32'd1, 7'd1);
    send_coeff(63'd0);
    send_coeff(63'd2);
    drain();

    // Modulus one sends only zero digits; a count above the maximum is cut to 64.
    program_regs(63'd1, 32'd5, 7'd127);
    send_coeff(63'd0);
    send_coeff(63'd5);
    drain();

    // Modulus zero: no reduction, negative digits leave as raw two's complement.
    program_regs(63'd0, 32'd10, 7'd3);
    send_coeff(63'd0);
    send_coeff(63'd123456789);
    send_coeff(VALUE_MAX);
    drain();

    // Small prime modulus: recentered values, a coefficient above q, and one so large
    // that the high part overflows.
    program_regs(63'd101, 32'd16, 7'd2);
    send_coeff(63'd100);
    send_coeff(63'd51);
    send_coeff(63'd200);
    send_coeff(VALUE_MAX);
    drain();

    // Random phases. Each one programs a fresh setting while the block is empty and then
    // streams coefficients, most of them in range and spread over the interesting regions.
    // One phase uses the full 64 digits with few items, since each such item is slow.
    for (ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 3))
        0: q = 63'($urandom_range(3, 1000));
        1: begin
          w = $urandom_range(2, 63);
          q = rand63() >> (63 - w);
          q[w-1] = 1'b1;
          if (q < 63'd3)
            q = 63'd3;
        end
        2: q = VALUE_MAX;
        default: q = 63'd2147483647;
      endcase
      case ($urandom_range(0, 3))
        0: b = $urandom_range(2, 16);
        1: b = 32'd1 << $urandom_range(1, 31);
        2: begin
          b = $urandom;
          if (b < 32'd2)
            b = 32'd2;
        end
        default: b = BASE_MAX;
      endcase
      if (ph == 0) begin
        q = VALUE_MAX;
        b = BASE_MAX;
      end else if (ph == 1) begin
        q = 63'd3;
        b = 32'd2;
      end
      n     = (ph == 5) ? 7'd64 : 7'($urandom_range(2, 6));
      items = (ph == 5) ? 4 : 18;
      calm  = (ph % 4 == 2);

      drain();
      program_regs(q, b, n);
      for (i = 0; i < items; i++) begin
        case ($urandom_range(0, 15))
          0: c = 63'($urandom_range(0, 3));
          1: c = q / 2 - 63'd1 + 63'($urandom_range(0, 2));
          2: c = q - 63'd1 - 63'($urandom_range(0, 1));
          3: begin
            // Out-of-range noise: a coefficient not below the modulus.
            c = rand63();
            if (c < q)
              c = VALUE_MAX;
          end
          default: c = rand63() % q;
        endcase
        send_coeff(c);
        // Once in the run the sender holds off in mid phase until the block is empty.
        if (ph == 7 && i == 9)
          drain();
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && digits_owed == 0)
      $display("[balanced_digit_decomposer_top] OK");
    else
      $display("[balanced_digit_decomposer_top] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
src/bdd_pkg.sv
src/bdd_chan_if.sv
src/bdd_div.sv
src/balanced_digit_decomposer_top.sv
verif/bdd_digit_checker.sv
verif/tb_top.sv
